/* hdl/rc_pkg.sv */
// ----------------------------------------------------------------------------
// rc_pkg
// Shared widths and types for the rank compression block.
// ----------------------------------------------------------------------------
package rc_pkg;

  // fixed field widths of the payload
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int RANK_W  = 7;

  // status from the rank unit to the sequencer
  typedef struct packed {
    logic              done;
    logic [RANK_W-1:0] rank;
  } rc_rank_stat_t;

endpackage

/* hdl/rc_store.sv */
// ----------------------------------------------------------------------------
// rc_store
// Value store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rc_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [rc_pkg::VALUE_W-1:0] wr_data,
  input  logic [AW-1:0]                     rd_addr_a,
  output logic signed [rc_pkg::VALUE_W-1:0] rd_data_a,
  input  logic [AW-1:0]                     rd_addr_b,
  output logic signed [rc_pkg::VALUE_W-1:0] rd_data_b
);

  logic signed [rc_pkg::VALUE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

/* hdl/rc_rank_unit.sv */
// ----------------------------------------------------------------------------
// rc_rank_unit
// Sweeps the store for one entry and counts the entries ranked below it.
// ----------------------------------------------------------------------------
module rc_rank_unit #(
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [AW-1:0]                     emit_idx,
  input  logic [AW-1:0]                     last_idx,
  output logic [AW-1:0]                     cmp_addr,
  input  logic signed [rc_pkg::VALUE_W-1:0] mine_data,
  input  logic signed [rc_pkg::VALUE_W-1:0] other_data,
  output rc_pkg::rc_rank_stat_t             stat
);

  localparam int RW = rc_pkg::RANK_W;

  logic          active;
  logic          issued_all;
  logic [AW-1:0] issue_idx;
  logic          pipe_vld;
  logic [AW-1:0] pipe_idx;
  logic [CW-1:0] acc;
  logic [CW-1:0] acc_next;
  logic          below;
  logic          done;
  logic [RW-1:0] rank;

  assign cmp_addr = issue_idx;

  // smaller value, or equal value at an earlier position
  assign below = (other_data < mine_data) ||
                 ((other_data == mine_data) && (pipe_idx < emit_idx));
  assign acc_next = (pipe_vld && below) ? acc + 1'b1 : acc;

  // read issue and compare pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      issued_all <= 1'b0;
      issue_idx  <= '0;
      pipe_vld   <= 1'b0;
      done       <= 1'b0;
    end else if (start) begin
      active     <= 1'b1;
      issued_all <= 1'b0;
      issue_idx  <= '0;
      pipe_vld   <= 1'b0;
      done       <= 1'b0;
    end else begin
      pipe_vld <= active && !issued_all;
      done     <= 1'b0;
      if (active && !issued_all) begin
        if (issue_idx == last_idx) begin
          issued_all <= 1'b1;
        end else begin
          issue_idx <= issue_idx + 1'b1;
        end
      end
      if (pipe_vld && (pipe_idx == last_idx)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  // payload: compare index, accumulator and final rank
  always_ff @(posedge clk) begin
    pipe_idx <= issue_idx;
    if (start) begin
      acc <= CW'(1);
    end else begin
      acc <= acc_next;
    end
    if (pipe_vld && (pipe_idx == last_idx)) begin
      rank <= RW'(acc_next);
    end
  end

  assign stat.done = done;
  assign stat.rank = rank;

endmodule

/* hdl/rank_compression.sv */
// ----------------------------------------------------------------------------
// rank_compression
// Loads a set of signed values and returns each one with its rank, in load
// order; equal values are ranked by position.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | fields
//  ---------+--------------+--------------+----------------------------------
//  item     | item_valid   | item_stall   | value, last_item
//  result   | result_valid | result_stall | position, value_out, rank,
//           |              |              | overflow, last_result
//
// loading takes one item per cycle while item_stall is low; items beyond MAX_COUNT are dropped
// each result of a set passes through a start state, a sweep (one store read
// per compared entry through the second read port, then the registered read
// and the compare) and a state that transfers the result
// item_stall is high from the last item of a set until its final result
// has been transferred; a stalled result holds the sequencer in place
// synchronous reset clears the sequencer, counts and flags; no store clear
// ----------------------------------------------------------------------------
module rank_compression #(
  parameter int MAX_COUNT = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic signed [rc_pkg::VALUE_W-1:0]  value,
  input  logic                               last_item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [rc_pkg::POS_W-1:0]           position,
  output logic signed [rc_pkg::VALUE_W-1:0]  value_out,
  output logic [rc_pkg::RANK_W-1:0]          rank,
  output logic                               overflow,
  output logic                               last_result
);

  localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int PW = rc_pkg::POS_W;

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_START = 4'b0010,
    S_SWEEP = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                            state;
  logic [CW-1:0]                     item_count;
  logic                              overflow_flag;
  logic [AW-1:0]                     emit_idx;
  logic [AW-1:0]                     last_idx;
  logic                              in_xfer;
  logic                              out_xfer;
  logic                              store_wr;
  logic signed [rc_pkg::VALUE_W-1:0] mine_data;
  logic signed [rc_pkg::VALUE_W-1:0] other_data;
  logic [AW-1:0]                     cmp_addr;
  rc_pkg::rc_rank_stat_t             stat;

  assign item_stall = (state != S_LOAD);
  assign in_xfer    = item_valid && !item_stall;
  assign out_xfer   = result_valid && !result_stall;
  assign store_wr   = in_xfer && (item_count < CW'(MAX_COUNT));
  assign last_idx   = AW'(item_count - 1'b1);

  rc_store #(
    .DEPTH (MAX_COUNT),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (store_wr),
    .wr_addr   (AW'(item_count)),
    .wr_data   (value),
    .rd_addr_a (emit_idx),
    .rd_data_a (mine_data),
    .rd_addr_b (cmp_addr),
    .rd_data_b (other_data)
  );

  rc_rank_unit #(
    .AW (AW),
    .CW (CW)
  ) u_rank (
    .clk        (clk),
    .rst        (rst),
    .start      (state == S_START),
    .emit_idx   (emit_idx),
    .last_idx   (last_idx),
    .cmp_addr   (cmp_addr),
    .mine_data  (mine_data),
    .other_data (other_data),
    .stat       (stat)
  );

  // sequencer, counts and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      item_count    <= '0;
      overflow_flag <= 1'b0;
      emit_idx      <= '0;
      result_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (store_wr) begin
              item_count <= item_count + 1'b1;
            end else begin
              overflow_flag <= 1'b1;
            end
            if (last_item) begin
              emit_idx <= '0;
              state    <= S_START;
            end
          end
        end
        S_START: begin
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          if (stat.done) begin
            result_valid <= 1'b1;
            state        <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_xfer) begin
            result_valid <= 1'b0;
            if (emit_idx == last_idx) begin
              item_count    <= '0;
              overflow_flag <= 1'b0;
              emit_idx      <= '0;
              state         <= S_LOAD;
            end else begin
              emit_idx <= emit_idx + 1'b1;
              state    <= S_START;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // result register, loaded when a sweep finishes
  always_ff @(posedge clk) begin
    if ((state == S_SWEEP) && stat.done) begin
      position    <= PW'(emit_idx);
      value_out   <= mine_data;
      rank        <= stat.rank;
      overflow    <= overflow_flag;
      last_result <= (emit_idx == last_idx);
    end
  end

`ifndef SYNTH
  // items are only taken while no result is pending
  assert property (@(posedge clk) disable iff (rst) !item_stall |-> !result_valid)
    else $error("item taken while a result is pending");

  // a finished sweep only arrives while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst) stat.done |-> (state == S_SWEEP))
    else $error("rank unit finished outside a sweep");

  // the stored count never exceeds the capacity
  assert property (@(posedge clk) disable iff (rst) item_count <= CW'(MAX_COUNT))
    else $error("item count beyond capacity");

  // the final result of a set leaves the block ready for a new set
  assert property (@(posedge clk) disable iff (rst)
    (out_xfer && last_result) |=> ((item_count == '0) && !overflow_flag))
    else $error("set not cleared after its final result");
`endif

endmodule

/* dv/rank_compression_test.sv */
// ----------------------------------------------------------------------------
// rank_compression_test
// Self-checking bench for the rank compression block. Sets of signed values
// are streamed in and every returned result is checked against a ranking
// worked out here: value, position, rank (ties by position), overflow and
// last marker. Covers single-item and full sets, dropped items, runs of
// equal values, extreme values, random idling, a long receiver hold-off and
// a sender pause that waits for the block to drain.
// ----------------------------------------------------------------------------
module rank_compression_test;

  localparam int STORE_DEPTH    = 64;
  localparam int ITEM_TARGET    = 370;
  localparam int IDLE_PCT       = 34;
  localparam int HOLD_AT_ITEM   = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int REPORT_LIMIT   = 10;

  typedef enum int {VK_WIDE, VK_TIES, VK_EDGES, VK_MIXED} value_kind_t;

  // one item waiting to be offered
  typedef struct {
    logic signed [rc_pkg::VALUE_W-1:0] value;
    logic                              last;
    logic                              drain_first;
  } load_item_t;

  // one ranked value as the block should return it
  typedef struct {
    logic [rc_pkg::POS_W-1:0]          position;
    logic signed [rc_pkg::VALUE_W-1:0] value;
    logic [rc_pkg::RANK_W-1:0]         rank;
    logic                              overflow;
    logic                              last;
  } ranked_value_t;

  logic                              clk;
  logic                              rst          = 1'b1;
  logic                              item_valid   = 1'b0;
  logic                              item_stall;
  logic signed [rc_pkg::VALUE_W-1:0] value        = '0;
  logic                              last_item    = 1'b0;
  logic                              result_valid;
  logic                              result_stall = 1'b0;
  logic [rc_pkg::POS_W-1:0]          position;
  logic signed [rc_pkg::VALUE_W-1:0] value_out;
  logic [rc_pkg::RANK_W-1:0]         rank;
  logic                              overflow;
  logic                              last_result;

  load_item_t                        item_backlog[$];
  ranked_value_t                     rank_backlog[$];
  logic signed [rc_pkg::VALUE_W-1:0] loaded_values[$];
  logic                              set_overflow = 1'b0;

  int items_seen     = 0;
  int results_seen   = 0;
  int sets_closed    = 0;
  int sets_returned  = 0;
  int overflow_sets  = 0;
  int largest_set    = 0;
  int mismatches     = 0;
  int closes_sent    = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int idle_cycles    = 0;

  logic calm;

  rank_compression #(
    .MAX_COUNT(STORE_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .value        (value),
    .last_item    (last_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .position     (position),
    .value_out    (value_out),
    .rank         (rank),
    .overflow     (overflow),
    .last_result  (last_result)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // a window with no idling on either side
  assign calm = (items_seen >= 150) && (items_seen < 230);

  // ranks for the set just closed: one plus the smaller values and earlier equal ones
  task automatic rank_set();
    ranked_value_t entry;
    int            n;
    int            r;
    n = loaded_values.size();
    for (int i = 0; i < n; i++) begin
      r = 1;
      for (int j = 0; j < n; j++) begin
        if (loaded_values[j] < loaded_values[i] ||
            (loaded_values[j] == loaded_values[i] && j < i)) begin
          r++;
        end
      end
      entry.position = i[rc_pkg::POS_W-1:0];
      entry.value    = loaded_values[i];
      entry.rank     = r[rc_pkg::RANK_W-1:0];
      entry.overflow = set_overflow;
      entry.last     = (i == n - 1);
      rank_backlog.push_back(entry);
    end
    sets_closed++;
    if (set_overflow) begin
      overflow_sets++;
    end
    if (n > largest_set) begin
      largest_set = n;
    end
    loaded_values.delete();
    set_overflow = 1'b0;
  endtask

  function automatic logic signed [rc_pkg::VALUE_W-1:0] pick_value(value_kind_t kind);
    int t;
    unique case (kind)
      VK_WIDE: begin
        return $urandom;
      end
      VK_TIES: begin
        t = $urandom_range(4);
        return t - 2;
      end
      VK_EDGES: begin
        unique case ($urandom_range(5))
          0:       return 32'sh8000_0000;
          1:       return 32'sh8000_0001;
          2:       return 32'sh7fff_ffff;
          3:       return 32'sh7fff_fffe;
          4:       return 32'sh0000_0000;
          default: return 32'shffff_ffff;
        endcase
      end
      default: begin
        return pick_value(value_kind_t'($urandom_range(2)));
      end
    endcase
  endfunction

  task automatic add_item(logic signed [rc_pkg::VALUE_W-1:0] v, logic last, logic drain);
    load_item_t it;
    it.value       = v;
    it.last        = last;
    it.drain_first = drain;
    item_backlog.push_back(it);
  endtask

  task automatic add_set(int n, value_kind_t kind, logic drain);
    for (int i = 0; i < n; i++) begin
      add_item(pick_value(kind), i == n - 1, drain && i == 0);
    end
  endtask

  // item driver: hold while stalled, otherwise offer the next one or idle
  always @(posedge clk) begin : drive_items
    logic                              nv;
    logic signed [rc_pkg::VALUE_W-1:0] nval;
    logic                              nlast;
    nv    = item_valid;
    nval  = value;
    nlast = last_item;
    if (rst) begin
      nv = 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (item_valid && last_item) begin
        closes_sent++;
      end
      nv = 1'b0;
      if (item_backlog.size() > 0 &&
          !(item_backlog[0].drain_first && sets_returned != closes_sent) &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nv    = 1'b1;
        nval  = item_backlog[0].value;
        nlast = item_backlog[0].last;
        void'(item_backlog.pop_front());
      end
    end
    item_valid <= nv;
    value      <= nval;
    last_item  <= nlast;
  end

  // result receiver: one long hold-off, otherwise random stalls
  always @(posedge clk) begin : receive_results
    logic stall_next;
    stall_next = 1'b0;
    if (!rst) begin
      if (!hold_done && items_seen >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        stall_next = !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
    result_stall <= stall_next;
  end

  // monitor: check results first, then take in the accepted item
  always @(posedge clk) begin : watch_transfers
    ranked_value_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (rank_backlog.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected result: pos %0d value %0d rank %0d ovf %0b last %0b",
                     position, value_out, rank, overflow, last_result);
          end
        end else begin
          want = rank_backlog.pop_front();
          if (want.last) begin
            sets_returned++;
          end
          if (position !== want.position || value_out !== want.value ||
              rank !== want.rank || overflow !== want.overflow ||
              last_result !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("mismatch: expected pos %0d value %0d rank %0d ovf %0b last %0b",
                       want.position, want.value, want.rank, want.overflow, want.last);
              $display("          actual   pos %0d value %0d rank %0d ovf %0b last %0b",
                       position, value_out, rank, overflow, last_result);
            end
          end
        end
      end
      if (item_valid && !item_stall) begin
        items_seen++;
        if (loaded_values.size() < STORE_DEPTH) begin
          loaded_values.push_back(value);
        end else begin
          set_overflow = 1'b1;
        end
        if (last_item) begin
          rank_set();
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin : watchdog
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no transfer", idle_cycles);
      $display("** rank_compression: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int n;
    bit full_done;
    bit over_done;
    full_done = 1'b0;
    over_done = 1'b0;

    // single-value sets at both extremes
    add_item(32'sh7fff_ffff, 1'b1, 1'b0);
    add_item(32'sh8000_0000, 1'b1, 1'b0);
    // mixed signs, extremes and repeated values
    add_item(32'sh0000_0000, 1'b0, 1'b0);
    add_item(32'shffff_ffff, 1'b0, 1'b0);
    add_item(32'sh0000_0001, 1'b0, 1'b0);
    add_item(32'sh8000_0000, 1'b0, 1'b0);
    add_item(32'sh7fff_ffff, 1'b0, 1'b0);
    add_item(32'shffff_ffff, 1'b0, 1'b0);
    add_item(32'sh0000_0000, 1'b0, 1'b0);
    add_item(32'sh0000_0001, 1'b1, 1'b0);
    // all equal, offered only once the block has drained
    add_item(32'sh0000_0005, 1'b0, 1'b1);
    add_item(32'sh0000_0005, 1'b0, 1'b0);
    add_item(32'sh0000_0005, 1'b1, 1'b0);
    // descending pair
    add_item(32'sh7fff_ffff, 1'b0, 1'b0);
    add_item(32'sh8000_0000, 1'b1, 1'b0);

    // random sets, with one exactly full and one overfull set
    while (item_backlog.size() < ITEM_TARGET) begin
      if (!full_done && item_backlog.size() >= 100) begin
        full_done = 1'b1;
        n = STORE_DEPTH;
      end else if (!over_done && item_backlog.size() >= 260) begin
        over_done = 1'b1;
        n = STORE_DEPTH + 3;
      end else if ($urandom_range(11) == 0) begin
        n = $urandom_range(24, 11);
      end else begin
        n = $urandom_range(8, 1);
      end
      add_set(n, value_kind_t'($urandom_range(3)), $urandom_range(9) == 0);
    end

    @(negedge rst);
    while (item_backlog.size() > 0 || item_valid) begin
      @(posedge clk);
    end
    while (rank_backlog.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    mismatches += rank_backlog.size();
    $display("covered %0d items in %0d sets (%0d overflowed, largest %0d values)",
             items_seen, sets_closed, overflow_sets, largest_set);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("** rank_compression: PASSED **");
    end else begin
      $display("** rank_compression: FAILED **");
    end
    $finish;
  end

endmodule
